@@ rtl/knn_pkg.sv @@
`timescale 1ns / 1ps

package knn_pkg;

  // command field codes
  localparam logic CMD_CANDIDATE = 1'b0;
  localparam logic CMD_VOTE      = 1'b1;

  // configuration register indexes
  localparam logic REG_NEIGHBOUR_COUNT = 1'b0;
  localparam logic REG_EMPTY_DISTANCE  = 1'b1;

  localparam int CFG_DATA_W = 48;
  localparam int NCNT_W     = 5;
  localparam int NCNT_RST   = 5;
  localparam int EMPTY_W    = 48;

  // labels in half units
  localparam logic [1:0] LAB_ZERO = 2'd0;
  localparam logic [1:0] LAB_HALF = 2'd1;
  localparam logic [1:0] LAB_ONE  = 2'd2;

  // prediction codes
  localparam logic [1:0] PRED_ZERO = 2'd0;
  localparam logic [1:0] PRED_ONE  = 2'd1;
  localparam logic [1:0] PRED_TIE  = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DONE
  } vote_state_e;

  typedef struct packed {
    logic insert;  // candidate transfer this cycle
    logic drain;   // shift every slot one place toward slot 0
    logic clear;   // reload every slot with the empty entry
  } cell_ctrl_t;

endpackage

@@ rtl/knn_cell.sv @@
`timescale 1ns / 1ps

module knn_cell #(
  parameter int DISTANCE_BITS = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  knn_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     active_i,
  input  logic [DISTANCE_BITS-1:0] cand_dist_i,
  input  logic [1:0]               cand_lab_i,
  input  logic [DISTANCE_BITS-1:0] empty_dist_i,
  input  logic [DISTANCE_BITS-1:0] rst_dist_i,
  input  logic [DISTANCE_BITS-1:0] prev_dist_i,
  input  logic [1:0]               prev_lab_i,
  input  logic                     prev_found_i,
  input  logic [DISTANCE_BITS-1:0] next_dist_i,
  input  logic [1:0]               next_lab_i,
  output logic [DISTANCE_BITS-1:0] dist_o,
  output logic [1:0]               lab_o,
  output logic                     found_o
);

  logic [DISTANCE_BITS-1:0] dist_q, dist_d;
  logic [1:0]               lab_q, lab_d;
  logic                     hit;

  // first active slot with a distance >= candidate takes it
  assign hit     = active_i && (cand_dist_i <= dist_q);
  assign found_o = prev_found_i || hit;

  always_comb begin
    dist_d = dist_q;
    lab_d  = lab_q;
    if (ctrl_i.clear) begin
      dist_d = empty_dist_i;
      lab_d  = knn_pkg::LAB_HALF;
    end else if (ctrl_i.drain) begin
      dist_d = next_dist_i;
      lab_d  = next_lab_i;
    end else if (ctrl_i.insert && active_i) begin
      if (prev_found_i) begin
        dist_d = prev_dist_i;
        lab_d  = prev_lab_i;
      end else if (hit) begin
        dist_d = cand_dist_i;
        lab_d  = cand_lab_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= rst_dist_i;
      lab_q  <= knn_pkg::LAB_HALF;
    end else begin
      dist_q <= dist_d;
      lab_q  <= lab_d;
    end
  end

  assign dist_o = dist_q;
  assign lab_o  = lab_q;

endmodule

@@ rtl/knn_top_k_vote.sv @@
// Candidate: one transfer per cycle while idle, no result; the list takes it at the transfer edge.
// Vote: input stalls through K drain steps through the cell chain plus one finish step, longer
//   while the previous result still waits; the result is registered at the finish step, which
//   waits until the result register is free.
// Candidates are taken while a result waits; a second vote waits for the result register.
// Reset (async, active low): K = 5, empty distance all ones, every slot empty, count zero.
`timescale 1ns / 1ps

module knn_top_k_vote #(
  parameter int MAX_NEIGHBOURS = 16,
  parameter int DISTANCE_BITS  = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [knn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [DISTANCE_BITS-1:0]       distance_i,
  input  logic                           candidate_label_i,
  input  logic                           actual_label_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     prediction_o,
  output logic                           correct_o,
  output logic [5:0]                     label_sum_halves_o,
  output logic [15:0]                    correct_count_o
);

  localparam int KW    = $clog2(MAX_NEIGHBOURS + 1);
  localparam int SUM_W = $clog2(2 * MAX_NEIGHBOURS + 1);
  localparam int KRst  = (knn_pkg::NCNT_RST > MAX_NEIGHBOURS) ? MAX_NEIGHBOURS
                                                              : knn_pkg::NCNT_RST;
  localparam logic [DISTANCE_BITS-1:0] EmptyRst =
    DISTANCE_BITS'({knn_pkg::EMPTY_W{1'b1}});

  // ---------------------------------------------------------------------------
  // Configuration. K is clamped to 1..MAX_NEIGHBOURS when written, so the rest
  // of the design only ever sees a legal count.
  // ---------------------------------------------------------------------------
  logic [KW-1:0]            k_q, k_wr;
  logic [DISTANCE_BITS-1:0] empty_q;
  logic [knn_pkg::NCNT_W-1:0] ncnt_wr;

  assign ncnt_wr = cfg_data_i[knn_pkg::NCNT_W-1:0];

  always_comb begin
    if (ncnt_wr == '0) begin
      k_wr = KW'(1);
    end else if (int'(ncnt_wr) > MAX_NEIGHBOURS) begin
      k_wr = KW'(MAX_NEIGHBOURS);
    end else begin
      k_wr = KW'(ncnt_wr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= KW'(KRst);
      empty_q <= EmptyRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        knn_pkg::REG_NEIGHBOUR_COUNT: k_q     <= k_wr;
        knn_pkg::REG_EMPTY_DISTANCE:  empty_q <= DISTANCE_BITS'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  knn_pkg::vote_state_e state_q, state_d;
  knn_pkg::cell_ctrl_t  ctrl;

  logic              in_xfer, vote_xfer, cand_xfer;
  logic              out_free, finish;
  logic [KW-1:0]     cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              actual_q;
  logic [15:0]       total_q, total_d;
  logic              out_valid_q;
  logic [1:0]        pred;
  logic              ok;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign vote_xfer = in_xfer && (command_i == knn_pkg::CMD_VOTE);
  assign cand_xfer = in_xfer && (command_i == knn_pkg::CMD_CANDIDATE);
  assign out_free  = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      knn_pkg::ST_IDLE: if (vote_xfer) state_d = knn_pkg::ST_SUM;
      knn_pkg::ST_SUM:  if (cnt_q == KW'(1)) state_d = knn_pkg::ST_DONE;
      knn_pkg::ST_DONE: if (out_free) state_d = knn_pkg::ST_IDLE;
      default:          state_d = knn_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    ctrl       = '0;
    finish     = 1'b0;
    case (state_q)
      knn_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl.insert = cand_xfer;
      end
      knn_pkg::ST_SUM: begin
        ctrl.drain = 1'b1;
      end
      knn_pkg::ST_DONE: begin
        finish     = out_free;
        ctrl.clear = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= knn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain. On insert the found flag ripples from slot 0 down; on a drain
  // every slot takes its right neighbor and slot 0 falls into the accumulator.
  // ---------------------------------------------------------------------------
  logic [DISTANCE_BITS-1:0] dist_a  [MAX_NEIGHBOURS+1];
  logic [1:0]               lab_a   [MAX_NEIGHBOURS+1];
  logic                     found_a [MAX_NEIGHBOURS+1];
  logic [1:0]               cand_lab;

  assign cand_lab = candidate_label_i ? knn_pkg::LAB_ONE : knn_pkg::LAB_ZERO;

  assign dist_a[MAX_NEIGHBOURS] = empty_q;
  assign lab_a[MAX_NEIGHBOURS]  = knn_pkg::LAB_HALF;
  assign found_a[0]             = 1'b0;

  logic [DISTANCE_BITS-1:0] prev_dist [MAX_NEIGHBOURS];
  logic [1:0]               prev_lab  [MAX_NEIGHBOURS];

  for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
    logic [DISTANCE_BITS-1:0] dist_c;
    logic [1:0]               lab_c;
    logic                     found_c;

    if (i == 0) begin : g_head
      assign prev_dist[i] = distance_i;
      assign prev_lab[i]  = cand_lab;
    end else begin : g_body
      assign prev_dist[i] = dist_a[i-1];
      assign prev_lab[i]  = lab_a[i-1];
    end

    knn_cell #(
      .DISTANCE_BITS (DISTANCE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .active_i     (KW'(i) < k_q),
      .cand_dist_i  (distance_i),
      .cand_lab_i   (cand_lab),
      .empty_dist_i (empty_q),
      .rst_dist_i   (EmptyRst),
      .prev_dist_i  (prev_dist[i]),
      .prev_lab_i   (prev_lab[i]),
      .prev_found_i (found_a[i]),
      .next_dist_i  (dist_a[i+1]),
      .next_lab_i   (lab_a[i+1]),
      .dist_o       (dist_c),
      .lab_o        (lab_c),
      .found_o      (found_c)
    );

    assign dist_a[i]    = dist_c;
    assign lab_a[i]     = lab_c;
    assign found_a[i+1] = found_c;
  end

  // ---------------------------------------------------------------------------
  // Vote: K drain steps accumulate the labels of slots 0..K-1
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (vote_xfer) begin
      cnt_d = k_q;
      sum_d = '0;
    end else if (ctrl.drain) begin
      cnt_d = cnt_q - KW'(1);
      sum_d = sum_q + SUM_W'(lab_a[0]);
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    sum_q <= sum_d;
    if (vote_xfer) actual_q <= actual_label_i;
  end

  // sum is in half units, so K halves is the tie point
  always_comb begin
    if (sum_q < SUM_W'(k_q)) begin
      pred = knn_pkg::PRED_ZERO;
    end else if (sum_q > SUM_W'(k_q)) begin
      pred = knn_pkg::PRED_ONE;
    end else begin
      pred = knn_pkg::PRED_TIE;
    end
  end

  assign ok = (pred == {1'b0, actual_q});

  always_comb begin
    total_d = total_q;
    if (finish && ok && (total_q != knn_pkg::COUNT_MAX)) begin
      total_d = total_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      prediction_o       <= pred;
      correct_o          <= ok;
      label_sum_halves_o <= 6'(sum_q);
      correct_count_o    <= total_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/knn_chk.sv @@
`timescale 1ns / 1ps

module knn_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        command_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  prediction_o,
  input logic        correct_o,
  input logic [15:0] correct_count_o
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(prediction_o)
      && $stable(correct_count_o))
    else $error("result changed while stalled");

  a_pred_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> prediction_o != 2'd3)
    else $error("prediction code out of range");

  a_tie_wrong: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (prediction_o == knn_pkg::PRED_TIE) |-> !correct_o)
    else $error("tie reported as correct");

  // a vote transfer stalls the input for the drain
  a_vote_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == knn_pkg::CMD_VOTE) |=> !in_ready_o)
    else $error("input ready right after a vote");

endmodule

bind knn_top_k_vote knn_chk u_knn_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .command_i       (command_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .prediction_o    (prediction_o),
  .correct_o       (correct_o),
  .correct_count_o (correct_count_o)
);

@@ test/tb_knn_top_k_vote.sv @@
`timescale 1ns / 1ps

module tb_knn_top_k_vote;

  localparam int DW = 48;      // distance width
  localparam int MAXN = 16;    // slots in the list
  localparam logic [DW-1:0] DIST_MAX = '1;

  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off, fills the block up
  localparam int SETTLE = 2 * MAXN + 8; // covers the drain and finish steps of a vote plus margin
  localparam int MAX_REPORTS = 40;
  localparam longint TIMEOUT_NS = 30_000_000;

  // one vote result
  typedef struct packed {
    logic [1:0]  pred;
    logic        ok;
    logic [5:0]  sum;
    logic [15:0] cnt;
  } vote_t;

  // one input item
  typedef struct packed {
    logic          cmd;
    logic [DW-1:0] dval;
    logic          clab;
    logic          alab;
  } item_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // directed table row: either an item or a register write
  typedef struct packed {
    row_kind_e                      kind;
    logic                           idx;
    logic [knn_pkg::CFG_DATA_W-1:0] data;
    item_t                          it;
    bit                             typed;  // want holds a hand-written expectation
    vote_t                          want;
  } stim_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic                           cfg_idx_i;
  logic [knn_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           command_i;
  logic [DW-1:0]                  distance_i;
  logic                           candidate_label_i;
  logic                           actual_label_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [1:0]                     prediction_o;
  logic                           correct_o;
  logic [5:0]                     label_sum_halves_o;
  logic [15:0]                    correct_count_o;

  // predictor state: sorted list, labels in half units, config copy
  logic [DW-1:0]              nn_dist [MAXN];
  logic [1:0]                 nn_lab  [MAXN];
  logic [15:0]                hits;
  logic [knn_pkg::NCNT_W-1:0] k_reg;
  logic [DW-1:0]              empty_reg;

  vote_t     pending_votes[$];  // expected vote results, oldest first
  stim_row_t dir_rows[$];
  int        n_errors = 0;
  int        idle_pct = 0;      // chance of a gap on either side, percent
  bit        hold_req = 1'b0;   // asks the sink for one long hold-off

  knn_top_k_vote dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .distance_i         (distance_i),
    .candidate_label_i  (candidate_label_i),
    .actual_label_i     (actual_label_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .prediction_o       (prediction_o),
    .correct_o          (correct_o),
    .label_sum_halves_o (label_sum_halves_o),
    .correct_count_o    (correct_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // K of 0 acts as 1, anything above the slot count acts as the slot count
  function automatic int eff_k();
    if (k_reg == 0) return 1;
    if (k_reg > MAXN) return MAXN;
    return int'(k_reg);
  endfunction

  // every slot back to the empty entry, including slots beyond K
  function automatic void nn_clear();
    for (int i = 0; i < MAXN; i++) begin
      nn_dist[i] = empty_reg;
      nn_lab[i] = knn_pkg::LAB_HALF;
    end
  endfunction

  // candidate goes ahead of the first stored distance >= it; slot K-1 falls off
  function automatic void nn_insert(logic [DW-1:0] d, logic lab);
    int k;
    int pos;
    k = eff_k();
    pos = k;
    for (int i = k - 1; i >= 0; i--)
      if (d <= nn_dist[i]) pos = i;
    if (pos < k) begin
      for (int j = k - 1; j > pos; j--) begin
        nn_dist[j] = nn_dist[j - 1];
        nn_lab[j] = nn_lab[j - 1];
      end
      nn_dist[pos] = d;
      nn_lab[pos] = lab ? knn_pkg::LAB_ONE : knn_pkg::LAB_ZERO;
    end
  endfunction

  // sum K labels in halves: below K is class 0, above is class 1, K itself a tie
  function automatic vote_t nn_vote(logic actual);
    vote_t r;
    int k;
    int s;
    k = eff_k();
    s = 0;
    for (int i = 0; i < k; i++) s += nn_lab[i];
    if (s < k) r.pred = knn_pkg::PRED_ZERO;
    else if (s > k) r.pred = knn_pkg::PRED_ONE;
    else r.pred = knn_pkg::PRED_TIE;
    r.ok = (r.pred == {1'b0, actual});  // a tie never matches
    if (r.ok && hits != knn_pkg::COUNT_MAX) hits++;
    r.sum = s[5:0];
    r.cnt = hits;
    nn_clear();
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void cmp_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t %s: expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  function automatic void check_vote();
    vote_t want;
    if (pending_votes.size() == 0) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t result with none expected: expected nothing, got pred %0d count %0d",
                 $time, prediction_o, correct_count_o);
      return;
    end
    want = pending_votes.pop_front();
    cmp_field("prediction", want.pred, prediction_o);
    cmp_field("correct", want.ok, correct_o);
    cmp_field("label_sum_halves", want.sum, label_sum_halves_o);
    cmp_field("correct_count", want.cnt, correct_count_o);
  endfunction

  // ---------------------------------------------------------------- helpers

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [DW-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[DW-1:0];
  endfunction

  // mix of extremes, the current empty distance, a narrow band (equal
  // distances show up often there) and full-width values
  function automatic logic [DW-1:0] pick_dist();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIST_MAX;
      2:       return empty_reg;
      3, 4, 5: return DW'($urandom_range(0, 63));
      default: return rand48();
    endcase
  endfunction

  function automatic void add_item(logic cmd, logic [DW-1:0] d, logic cl, logic al);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.it.cmd = cmd;
    r.it.dval = d;
    r.it.clab = cl;
    r.it.alab = al;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_typed_vote(logic al, vote_t want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.it.cmd = knn_pkg::CMD_VOTE;
    r.it.alab = al;
    r.typed = 1'b1;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic idx, logic [knn_pkg::CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    dir_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------- driving
  // All tasks are entered and left right after a rising edge.

  // offer one item and hold it until the transfer; the predictor runs at
  // the transfer edge, so it sees exactly the accepted order
  task automatic send_item(item_t it, bit typed, vote_t want);
    vote_t guess;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= it.cmd;
    distance_i <= it.dval;
    candidate_label_i <= it.clab;
    actual_label_i <= it.alab;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (it.cmd == knn_pkg::CMD_VOTE) begin
      guess = nn_vote(it.alab);
      pending_votes.push_back(typed ? want : guess);
    end else begin
      nn_insert(it.dval, it.clab);
    end
  endtask

  // all results in, then let any trailing list update settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_votes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // waits again after dropping the enable so back-to-back writes never lower and
  // raise the enable in one step
  task automatic write_reg(logic idx, logic [knn_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == knn_pkg::REG_NEIGHBOUR_COUNT) k_reg = data[knn_pkg::NCNT_W-1:0];
    else empty_reg = data[knn_pkg::EMPTY_W-1:0];
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- watchdog

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_knn_top_k_vote: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- result side
  // Checks each transfer, then picks ready for the next cycle. The long
  // hold-off is counted here so the sender keeps offering meanwhile.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_vote();
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = gap_len() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    stim_row_t                      row;
    item_t                          it;
    logic [knn_pkg::CFG_DATA_W-1:0] data;
    int                             kval;
    int                             sent;
    int                             n;
    int                             mode;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = knn_pkg::REG_NEIGHBOUR_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = knn_pkg::CMD_CANDIDATE;
    distance_i = '0;
    candidate_label_i = 1'b0;
    actual_label_i = 1'b0;
    out_ready_i = 1'b0;

    k_reg = knn_pkg::NCNT_W'(knn_pkg::NCNT_RST);
    empty_reg = DIST_MAX;
    hits = '0;
    nn_clear();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // -- directed table --------------------------------------------------
    // Out of reset every slot is empty: K halves, a tie, whatever the label.
    add_typed_vote(1'b0, vote_t'{knn_pkg::PRED_TIE, 1'b0, 6'd5, 16'd0});
    add_typed_vote(1'b1, vote_t'{knn_pkg::PRED_TIE, 1'b0, 6'd5, 16'd0});
    add_item(knn_pkg::CMD_CANDIDATE, '0, 1'b1, 1'b0);        // smallest distance
    add_item(knn_pkg::CMD_CANDIDATE, DIST_MAX, 1'b0, 1'b0);  // ties the empty slots, goes ahead
    add_item(knn_pkg::CMD_CANDIDATE, 48'd100, 1'b1, 1'b0);
    add_item(knn_pkg::CMD_CANDIDATE, 48'd100, 1'b0, 1'b0);   // equal distance goes ahead
    add_item(knn_pkg::CMD_CANDIDATE, 48'd50, 1'b1, 1'b0);
    add_item(knn_pkg::CMD_CANDIDATE, 48'd60, 1'b0, 1'b1);    // list full, last entry drops
    add_item(knn_pkg::CMD_VOTE, '0, 1'b0, 1'b1);
    // K of zero acts as one; empty distance zero lands only at the next clear
    add_cfg(knn_pkg::REG_NEIGHBOUR_COUNT, '0);
    add_cfg(knn_pkg::REG_EMPTY_DISTANCE, '0);
    add_item(knn_pkg::CMD_CANDIDATE, 48'd10, 1'b1, 1'b0);
    add_item(knn_pkg::CMD_VOTE, DIST_MAX, 1'b1, 1'b1);
    add_item(knn_pkg::CMD_CANDIDATE, 48'd5, 1'b1, 1'b0);     // farther than every slot
    add_item(knn_pkg::CMD_VOTE, '0, 1'b0, 1'b0);
    add_item(knn_pkg::CMD_CANDIDATE, '0, 1'b0, 1'b1);        // equal to the zero empty slot
    add_item(knn_pkg::CMD_VOTE, '0, 1'b1, 1'b0);
    // K above the slot count acts as the full list; new empty distance
    // still waits for a clear, so these first two are dropped
    add_cfg(knn_pkg::REG_NEIGHBOUR_COUNT, knn_pkg::CFG_DATA_W'(31));
    add_cfg(knn_pkg::REG_EMPTY_DISTANCE, DIST_MAX);
    add_item(knn_pkg::CMD_CANDIDATE, 48'd7, 1'b1, 1'b0);
    add_item(knn_pkg::CMD_CANDIDATE, 48'd3, 1'b1, 1'b0);
    add_item(knn_pkg::CMD_VOTE, '0, 1'b0, 1'b1);
    add_item(knn_pkg::CMD_CANDIDATE, 48'd3, 1'b1, 1'b0);
    add_item(knn_pkg::CMD_VOTE, '0, 1'b0, 1'b0);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_reg(row.idx, row.data);
      end else begin
        send_item(row.it, row.typed, row.want);
      end
    end

    // -- random phases ---------------------------------------------------
    // Mostly well-formed queries (a run of candidates, then a vote) with
    // some lone items of any kind mixed in.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       kval = 0;
        1:       kval = 1;
        2:       kval = MAXN;
        3:       kval = 31;
        default: kval = $urandom_range(2, MAXN - 1);
      endcase
      data = rand48();  // upper bits of the K write are don't-care
      data[knn_pkg::NCNT_W-1:0] = knn_pkg::NCNT_W'(kval);
      write_reg(knn_pkg::REG_NEIGHBOUR_COUNT, data);
      case ($urandom_range(0, 3))
        0:       data = '0;
        1:       data = DIST_MAX;
        2:       data = knn_pkg::CFG_DATA_W'($urandom_range(0, 1000));
        default: data = rand48();
      endcase
      write_reg(knn_pkg::REG_EMPTY_DISTANCE, data);

      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 25;
        default: idle_pct = 60;
      endcase
      if (ph == 1) hold_req = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          it.cmd = 1'($urandom_range(0, 1));
          it.dval = rand48();
          it.clab = 1'($urandom_range(0, 1));
          it.alab = 1'($urandom_range(0, 1));
          send_item(it, 1'b0, '0);
          sent++;
        end else begin
          n = $urandom_range(0, 2 * eff_k() + 2);
          mode = $urandom_range(0, 3);  // all zero, all one, or mixed labels
          for (int c = 0; c < n; c++) begin
            it.cmd = knn_pkg::CMD_CANDIDATE;
            it.dval = pick_dist();
            it.clab = (mode == 0) ? 1'b0 : (mode == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            it.alab = 1'($urandom_range(0, 1));
            send_item(it, 1'b0, '0);
          end
          it.cmd = knn_pkg::CMD_VOTE;
          it.dval = rand48();
          it.clab = 1'($urandom_range(0, 1));
          it.alab = 1'($urandom_range(0, 1));
          send_item(it, 1'b0, '0);
          sent += n + 1;
        end
      end
    end

    wait_drained();
    if (n_errors == 0) begin
      $display("tb_knn_top_k_vote: done, clean");
    end else begin
      $display("tb_knn_top_k_vote: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/knn_pkg.sv
rtl/knn_cell.sv
rtl/knn_top_k_vote.sv
rtl/knn_chk.sv
test/tb_knn_top_k_vote.sv
